>>> src/generation_tagged_seen_table_top_assert.svh
// Assertion macros for the seen-table checker.
// Assumes a clock named clk in the module that uses them.
`ifndef GENERATION_TAGGED_SEEN_TABLE_TOP_ASSERT_SVH
`define GENERATION_TAGGED_SEEN_TABLE_TOP_ASSERT_SVH

// Next-cycle implication, disabled while the given reset is asserted
`define GTST_ASSERT_NEXT(lbl, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("seen table assertion failed");

// Next-cycle implication, checked during reset too
`define GTST_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("seen table assertion failed");

`endif

>>> src/gtst_pkg.sv
// Shared types and constants for the generation-tagged seen table.
// No dependencies.
`default_nettype none

package gtst_pkg;

  localparam int INDEX_BITS  = 16;
  localparam int GEN_BITS    = 16;
  localparam int KEY_W       = 64;
  localparam int DEPTH_W     = 5;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;
  localparam int BYTE_CNT_W  = $clog2(KEY_W / 8);

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

  // Item kinds
  localparam logic KIND_CHECK   = 1'b0;
  localparam logic KIND_NEW_GEN = 1'b1;

  // Outcome classes
  localparam logic [1:0] OUT_SAME_DEPTH = 2'd0;
  localparam logic [1:0] OUT_SHALLOWER  = 2'd1;
  localparam logic [1:0] OUT_CONFLICT   = 2'd2;
  localparam logic [1:0] OUT_FILL       = 2'd3;

  typedef struct packed {
    logic               kind;
    logic [KEY_W-1:0]   key;
    logic [DEPTH_W-1:0] depth;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] outcome;
  } out_item_t;

  // One table entry as held in the RAM
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [DEPTH_W-1:0]  depth;
    logic [GEN_BITS-1:0] gen;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_HASH  = 5'b00100,
    ST_READ  = 5'b01000,
    ST_EVAL  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

>>> src/gtst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gtst_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> src/gtst_crc.sv
// Byte-serial CRC32C hash of a 64-bit key, low byte first, start value zero.
// Depends on gtst_pkg.
`default_nettype none

module gtst_crc
  import gtst_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [KEY_W-1:0]      key,
  output logic                       done,
  output logic      [INDEX_BITS-1:0] index
);

  logic [31:0]           crc_r,  crc_nxt;
  logic [KEY_W-1:0]      key_r,  key_nxt;
  logic [BYTE_CNT_W-1:0] cnt_r,  cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  // one reflected byte step: eight shift and conditional xor steps
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
    end
    return x;
  endfunction

  // step sequencing
  always_comb begin
    crc_nxt  = crc_r;
    key_nxt  = key_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      crc_nxt  = '0;
      key_nxt  = key;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      crc_nxt = crc_byte(crc_r, key_r[7:0]);
      key_nxt = key_r >> 8;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == {BYTE_CNT_W{1'b1}}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath needs no reset
  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    key_r <= key_nxt;
  end

  assign done  = done_r;
  assign index = crc_r[INDEX_BITS-1:0];

endmodule

`default_nettype wire

>>> src/generation_tagged_seen_table_top.sv
// Check item: load, 8 CRC byte steps, index capture, one RAM read, evaluate and write-back
// on a miss; evaluate waits while out_stall holds. in_stall stays high until the check is done.
// Invalidate item: advances the generation, no result. On generation wrap, and after reset, a
// clearing pass writes all 65536 entries, one a cycle; in_stall stays high during the pass.
// Reset (rst_n low, synchronous) sets the generation to 1 and starts the clearing pass.
// Depends on gtst_pkg, gtst_ram, gtst_crc.
`default_nettype none

module generation_tagged_seen_table_top
  import gtst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  state_t                state_r,   state_nxt;
  logic [INDEX_BITS-1:0] clr_idx_r, clr_idx_nxt;
  logic [GEN_BITS-1:0]   gen_r,     gen_nxt;
  logic                  out_vld_r, out_vld_nxt;
  out_item_t             out_r,     out_nxt;
  logic [INDEX_BITS-1:0] idx_r,     idx_nxt;
  logic [KEY_W-1:0]      key_r,     key_nxt;
  logic [DEPTH_W-1:0]    depth_r,   depth_nxt;

  logic                  accept;
  logic                  crc_start;
  logic                  crc_done;
  logic [INDEX_BITS-1:0] crc_idx;
  logic [GEN_BITS-1:0]   gen_inc;

  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_addr;
  entry_t                wr_entry;
  logic                  rd_en;
  entry_t                rd_entry;
  logic [ENTRY_W-1:0]    rd_word;

  logic                  same_gen;
  logic                  key_eq;
  logic                  hit;
  logic                  out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign crc_start = accept && (in_data.kind == KIND_CHECK);
  assign gen_inc   = gen_r + 1'b1;
  assign out_free  = !out_vld_r || !out_stall;

  gtst_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (crc_start),
    .key   (in_data.key),
    .done  (crc_done),
    .index (crc_idx)
  );

  gtst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_word)
  );

  assign rd_entry = entry_t'(rd_word);

  // hit decision on the entry just read
  assign same_gen = (rd_entry.gen == gen_r);
  assign key_eq   = (rd_entry.key == key_r);
  assign hit      = key_eq && (rd_entry.depth <= depth_r) && same_gen;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    gen_nxt     = gen_r;
    out_vld_nxt = out_vld_r && out_stall;
    out_nxt     = out_r;
    idx_nxt     = idx_r;
    key_nxt     = key_r;
    depth_nxt   = depth_r;
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    wr_entry    = '{key: key_r, depth: depth_r, gen: gen_r};
    rd_en       = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        wr_entry    = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == {INDEX_BITS{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_data.kind == KIND_NEW_GEN) begin
            if (gen_inc == '0) begin
              gen_nxt     = GEN_BITS'(1);
              clr_idx_nxt = '0;
              state_nxt   = ST_CLEAR;
            end else begin
              gen_nxt = gen_inc;
            end
          end else begin
            key_nxt   = in_data.key;
            depth_nxt = in_data.depth;
            state_nxt = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (crc_done) begin
          idx_nxt   = crc_idx;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        // read issued with the index registered in the previous cycle
        rd_en     = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_nxt.hit = hit;
          if (hit) begin
            out_nxt.outcome = (rd_entry.depth == depth_r) ? OUT_SAME_DEPTH : OUT_SHALLOWER;
          end else begin
            out_nxt.outcome = (same_gen && !key_eq) ? OUT_CONFLICT : OUT_FILL;
            wr_en           = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
      gen_r     <= GEN_BITS'(1);
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      gen_r     <= gen_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    idx_r   <= idx_nxt;
    key_r   <= key_nxt;
    depth_r <= depth_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> src/gtst_checker.sv
// Port-level checker for the seen table, bound to the top level.
// Depends on gtst_pkg and generation_tagged_seen_table_top_assert.svh.
`default_nettype none

`include "generation_tagged_seen_table_top_assert.svh"

module gtst_checker
  import gtst_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // stalled input item holds
  `GTST_ASSERT_NEXT(a_in_hold, rst_n, in_valid && in_stall, $stable(in_data))
  // stalled result holds
  `GTST_ASSERT_NEXT(a_out_hold, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  // reset always leads into the clearing pass
  `GTST_ASSERT_NEXT_ALWAYS(a_rst_clear, !rst_n, in_stall)
  // a check item blocks the input while it is hashed
  `GTST_ASSERT_NEXT(a_check_busy, rst_n,
                    in_valid && !in_stall && (in_data.kind == KIND_CHECK), in_stall)

endmodule

bind generation_tagged_seen_table_top gtst_checker u_gtst_checker (.*);

`default_nettype wire
